/* src/srb_pkg.sv */
// Shared types and constants for the stream reassembly buffer.
// Used by srb_front, srb_back and the top level; depends on nothing else.
package srb_pkg;

  localparam int STORE_BYTES = 32768;
  localparam int CHUNK_SLOTS = 16;
  localparam int STAMP_SLOTS = 16;

  localparam int SB_AW  = $clog2(STORE_BYTES);
  localparam int CH_W   = $clog2(CHUNK_SLOTS);
  localparam int ST_W   = $clog2(STAMP_SLOTS);
  localparam int SCAN_N = (CHUNK_SLOTS > STAMP_SLOTS) ? CHUNK_SLOTS : STAMP_SLOTS;
  localparam int SCAN_W = $clog2(SCAN_N);

  localparam int POS_W  = 31;
  localparam int LEN_W  = 16;
  localparam int TIME_W = 64;
  localparam int BYTE_W = 8;
  localparam int REG_W  = 16;

  localparam logic [REG_W-1:0] CAP_RST = 16'(1024 * 32);
  localparam logic [REG_W-1:0] GAP_RST = 16'(1024 * 4);
  localparam logic [REG_W-1:0] ABG_RST = 16'(1024);

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_MAX_GAP  = 2'd1;
  localparam logic [1:0] CFG_ALLOW    = 2'd2;

  typedef enum logic [1:0] {
    MODE_HDR  = 2'd0,
    MODE_PAY  = 2'd1,
    MODE_READ = 2'd2,
    MODE_EXP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_ACC    = 2'd0,
    ST_DROP   = 2'd1,
    ST_DIRECT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   seg_len;
    logic [LEN_W-1:0]   cap_len;
    logic [TIME_W-1:0]  time_val;
    logic [BYTE_W-1:0]  data;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [LEN_W-1:0]   contig;
    logic [TIME_W-1:0]  time_val;
    logic [BYTE_W-1:0]  data;
    logic               empty;
  } res_t;

  typedef struct packed {
    logic [REG_W-1:0] capacity;
    logic [REG_W-1:0] max_gap;
    logic [REG_W-1:0] allow;
  } cfg_t;

endpackage

/* src/srb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by srb_back for the byte store.
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/srb_front.sv */
// Front end: unpacks and classifies incoming requests into a two-entry queue.
// Depends on srb_pkg.
module srb_front
  import srb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [135:0] in_data_i,
  input  logic [1:0]   in_user_i,
  output logic         q_valid_o,
  output item_t        q_item_o,
  input  logic         q_ready_i
);

  item_t      fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  item_t      cls;
  logic       push, pop;

  always_comb begin
    cls.mode     = mode_e'(in_user_i);
    cls.pos      = in_data_i[30:0];
    cls.seg_len  = in_data_i[46:31];
    cls.cap_len  = in_data_i[62:47];
    cls.time_val = in_data_i[126:63];
    cls.data     = in_data_i[134:127];
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cls;
    end
  end

endmodule

/* src/srb_back.sv */
// Back end: sequencer that walks the chunk and timestamp tables one entry
// per cycle and owns the window state and the byte store. Depends on srb_pkg
// and srb_ram.
module srb_back
  import srb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_ready_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_HCHK, S_HLAST, S_HJUMP, S_HEVICT, S_CLA, S_CLB, S_CLC,
    S_OVL, S_OVLCHK, S_ESCAN, S_EDO, S_EFIN, S_RSCAN, S_RFIN
  } state_e;

  state_e state_q, ret_q;

  logic [CHUNK_SLOTS-1:0] chunk_vld_q;
  logic [POS_W-1:0]       chunk_start_q [CHUNK_SLOTS];
  logic [LEN_W-1:0]       chunk_len_q   [CHUNK_SLOTS];
  logic [STAMP_SLOTS-1:0] stamp_vld_q;
  logic [POS_W-1:0]       stamp_pos_q   [STAMP_SLOTS];
  logic [TIME_W-1:0]      stamp_val_q   [STAMP_SLOTS];

  logic [POS_W-1:0] head_q, hnew_q;
  logic [LEN_W-1:0] fill_q, pskip_q, pleft_q, len_q, prefix_q;
  logic [SB_AW-1:0] widx_q;
  item_t            it_q;
  logic [31:0]      end_q;
  logic             moved_q, hdr_cln_q;
  logic [SCAN_W-1:0] scan_q;
  logic             res_vld_q;
  res_t             res_q;

  // Running best entries of the current table walk.
  logic             a_hit_q, b_hit_q, r_hit_q, l_hit_q, fc_hit_q, sm_hit_q, sf_hit_q, any_q;
  logic [CH_W-1:0]  a_idx_q, r_idx_q, l_idx_q, fc_idx_q;
  logic [ST_W-1:0]  sm_idx_q, sf_idx_q;
  logic [POS_W-1:0] a_start_q, r_start_q, l_start_q, b_pos_q;
  logic [LEN_W-1:0] a_len_q, r_len_q, l_len_q;
  logic [TIME_W-1:0] b_val_q;

  logic [CH_W-1:0]  ci;
  logic [ST_W-1:0]  si;
  logic             c_v, s_v, first, scan_last;
  logic [POS_W-1:0] c_s, s_p;
  logic [LEN_W-1:0] c_l;
  logic [TIME_W-1:0] s_t;
  logic             ah, bh, rh, lh, fh, smh, sfh, anyh;
  logic [LEN_W-1:0] cap_eff;
  logic [31:0]      end_c, diff_c, aend, endp, evict_b;
  logic [BYTE_W-1:0] ram_rdata;
  logic             ram_we;
  res_t             rd_res;

  // Result word that carries only a status and the empty flag.
  function automatic res_t plain_res(status_e st, logic empty);
    res_t r;
    r        = '0;
    r.status = st;
    r.empty  = empty;
    return r;
  endfunction

  assign ci        = CH_W'(scan_q);
  assign si        = ST_W'(scan_q);
  assign c_v       = (32'(scan_q) < 32'(CHUNK_SLOTS)) && chunk_vld_q[ci];
  assign s_v       = (32'(scan_q) < 32'(STAMP_SLOTS)) && stamp_vld_q[si];
  assign c_s       = chunk_start_q[ci];
  assign c_l       = chunk_len_q[ci];
  assign s_p       = stamp_pos_q[si];
  assign s_t       = stamp_val_q[si];
  assign first     = (scan_q == '0);
  assign scan_last = (scan_q == SCAN_W'(SCAN_N - 1));

  // On the first step of a walk the running results start afresh.
  assign ah   = a_hit_q  && !first;
  assign bh   = b_hit_q  && !first;
  assign rh   = r_hit_q  && !first;
  assign lh   = l_hit_q  && !first;
  assign fh   = fc_hit_q && !first;
  assign smh  = sm_hit_q && !first;
  assign sfh  = sf_hit_q && !first;
  assign anyh = any_q    && !first;

  assign cap_eff = ({16'd0, cfg_i.capacity} < 32'(STORE_BYTES)) ? cfg_i.capacity
                                                                 : LEN_W'(STORE_BYTES);
  assign end_c   = {1'b0, it_q.pos} + 32'(len_q);
  assign diff_c  = end_c - {1'b0, head_q};
  assign aend    = {1'b0, a_start_q} + 32'(a_len_q);
  assign endp    = a_hit_q ? aend : {1'b0, head_q};
  assign evict_b = end_q - {1'b0, hnew_q};

  assign q_ready_o   = (state_q == S_IDLE) && (q_item_i.mode == MODE_PAY || !res_vld_q);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;
  assign ram_we      = (state_q == S_IDLE) && q_valid_i && q_item_i.mode == MODE_PAY &&
                       pskip_q == '0 && pleft_q != '0;

  always_comb begin
    rd_res          = '0;
    rd_res.time_val = '1;
    if (a_hit_q && aend > {1'b0, it_q.pos} && it_q.pos >= head_q &&
        (it_q.pos - head_q) <= POS_W'(fill_q)) begin
      rd_res.found  = 1'b1;
      rd_res.contig = LEN_W'(aend - {1'b0, it_q.pos});
      rd_res.data   = ram_rdata;
      if (b_hit_q) begin
        rd_res.time_val = b_val_q;
      end
    end
  end

  srb_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (q_item_i.data),
    .raddr_i (it_q.pos[SB_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      chunk_vld_q <= '0;
      stamp_vld_q <= '0;
      for (int i = 0; i < CHUNK_SLOTS; i++) begin
        chunk_start_q[i] <= '0;
        chunk_len_q[i]   <= '0;
      end
      for (int i = 0; i < STAMP_SLOTS; i++) begin
        stamp_pos_q[i] <= '0;
        stamp_val_q[i] <= '0;
      end
      head_q    <= '0;
      hnew_q    <= '0;
      fill_q    <= '0;
      pskip_q   <= '0;
      pleft_q   <= '0;
      widx_q    <= '0;
      len_q     <= '0;
      prefix_q  <= '0;
      it_q      <= '0;
      end_q     <= '0;
      moved_q   <= 1'b0;
      hdr_cln_q <= 1'b0;
      scan_q    <= '0;
      res_vld_q <= 1'b0;
      res_q     <= '0;
      a_hit_q <= 1'b0; b_hit_q <= 1'b0; r_hit_q <= 1'b0; l_hit_q <= 1'b0;
      fc_hit_q <= 1'b0; sm_hit_q <= 1'b0; sf_hit_q <= 1'b0; any_q <= 1'b0;
      a_idx_q <= '0; r_idx_q <= '0; l_idx_q <= '0; fc_idx_q <= '0;
      sm_idx_q <= '0; sf_idx_q <= '0;
      a_start_q <= '0; r_start_q <= '0; l_start_q <= '0; b_pos_q <= '0;
      a_len_q <= '0; r_len_q <= '0; l_len_q <= '0; b_val_q <= '0;
    end else begin
      if (res_vld_q && res_ready_i) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && q_ready_o) begin
            it_q     <= q_item_i;
            len_q    <= q_item_i.seg_len;
            prefix_q <= '0;
            unique case (q_item_i.mode)
              MODE_PAY: begin
                if (pskip_q != '0) begin
                  pskip_q <= pskip_q - LEN_W'(1);
                end else if (pleft_q != '0) begin
                  widx_q  <= widx_q + SB_AW'(1);
                  pleft_q <= pleft_q - LEN_W'(1);
                end
              end
              MODE_HDR: begin
                pskip_q <= '0;
                pleft_q <= '0;
                state_q <= S_HCHK;
              end
              MODE_EXP: begin
                pskip_q <= '0;
                pleft_q <= '0;
                state_q <= S_ESCAN;
              end
              default: state_q <= S_RSCAN;
            endcase
          end
        end

        S_HCHK: begin
          end_q <= end_c;
          if (len_q > cap_eff || len_q != it_q.cap_len) begin
            res_q     <= plain_res(ST_DIRECT, 1'b0);
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end else if (len_q == '0 || end_c <= {1'b0, head_q}) begin
            res_q     <= plain_res(ST_DROP, 1'b0);
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end else if (it_q.pos < head_q) begin
            // Segment starts before the window: cut off its prefix.
            prefix_q <= LEN_W'(head_q - it_q.pos);
            it_q.pos <= head_q;
            len_q    <= diff_c[LEN_W-1:0];
            if (diff_c[LEN_W-1:0] > fill_q) begin
              fill_q <= diff_c[LEN_W-1:0];
            end
            state_q  <= S_OVL;
          end else if (diff_c > {16'd0, fill_q}) begin
            state_q <= S_HLAST;
          end else begin
            state_q <= S_OVL;
          end
        end

        S_HLAST: begin
          a_hit_q <= ah || c_v;
          if (c_v && (!ah || c_s > a_start_q)) begin
            a_idx_q   <= ci;
            a_start_q <= c_s;
            a_len_q   <= c_l;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_HJUMP;
          end
        end

        S_HJUMP: begin
          if ({2'b0, it_q.pos} > {1'b0, endp} + 33'(cfg_i.max_gap)) begin
            hnew_q  <= (it_q.pos >= POS_W'(cfg_i.allow)) ? it_q.pos - POS_W'(cfg_i.allow)
                                                         : '0;
            moved_q <= 1'b1;
          end else begin
            hnew_q  <= head_q;
            moved_q <= 1'b0;
          end
          state_q <= S_HEVICT;
        end

        S_HEVICT: begin
          hdr_cln_q <= 1'b1;
          ret_q     <= S_OVL;
          if (evict_b > 32'(cap_eff)) begin
            head_q  <= POS_W'(end_q - 32'(cap_eff));
            fill_q  <= cap_eff;
            state_q <= S_CLA;
          end else begin
            head_q  <= hnew_q;
            fill_q  <= evict_b[LEN_W-1:0];
            state_q <= moved_q ? S_CLA : S_OVL;
          end
        end

        S_CLA: begin
          a_hit_q <= ah || (c_v && c_s <= head_q);
          if (c_v && c_s <= head_q && (!ah || c_s > a_start_q)) begin
            a_idx_q   <= ci;
            a_start_q <= c_s;
            a_len_q   <= c_l;
          end
          b_hit_q <= bh || (s_v && s_p <= head_q);
          if (s_v && s_p <= head_q && (!bh || s_p > b_pos_q)) begin
            b_pos_q <= s_p;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_CLB;
          end
        end

        S_CLB: begin
          if (a_hit_q && c_v && c_s <= a_start_q) begin
            chunk_vld_q[ci] <= 1'b0;
          end
          if (b_hit_q && s_v && s_p < b_pos_q) begin
            stamp_vld_q[si] <= 1'b0;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_CLC;
          end
        end

        S_CLC: begin
          if (a_hit_q) begin
            if (aend > {1'b0, head_q}) begin
              chunk_vld_q[a_idx_q]   <= 1'b1;
              chunk_start_q[a_idx_q] <= head_q;
              chunk_len_q[a_idx_q]   <= LEN_W'(aend - {1'b0, head_q});
            end else if (chunk_vld_q == '0 && !hdr_cln_q) begin
              fill_q <= '0;
            end
          end
          state_q <= ret_q;
        end

        S_OVL: begin
          r_hit_q <= rh || (c_v && c_s >= it_q.pos);
          if (c_v && c_s >= it_q.pos && (!rh || c_s < r_start_q)) begin
            r_idx_q   <= ci;
            r_start_q <= c_s;
            r_len_q   <= c_l;
          end
          l_hit_q <= lh || (c_v && c_s < it_q.pos);
          if (c_v && c_s < it_q.pos && (!lh || c_s > l_start_q)) begin
            l_idx_q   <= ci;
            l_start_q <= c_s;
            l_len_q   <= c_l;
          end
          fc_hit_q <= fh || (32'(scan_q) < 32'(CHUNK_SLOTS) && !chunk_vld_q[ci]);
          if (!fh && 32'(scan_q) < 32'(CHUNK_SLOTS) && !chunk_vld_q[ci]) begin
            fc_idx_q <= ci;
          end
          sm_hit_q <= smh || (s_v && s_p == it_q.pos);
          if (!smh && s_v && s_p == it_q.pos) begin
            sm_idx_q <= si;
          end
          sf_hit_q <= sfh || (32'(scan_q) < 32'(STAMP_SLOTS) && !stamp_vld_q[si]);
          if (!sfh && 32'(scan_q) < 32'(STAMP_SLOTS) && !stamp_vld_q[si]) begin
            sf_idx_q <= si;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_OVLCHK;
          end
        end

        S_OVLCHK: begin
          res_vld_q <= 1'b1;
          state_q   <= S_IDLE;
          if ((r_hit_q && end_q > {1'b0, r_start_q}) ||
              (l_hit_q && {1'b0, it_q.pos} < {1'b0, l_start_q} + 32'(l_len_q))) begin
            res_q <= plain_res(ST_DROP, 1'b0);
          end else if ((!sm_hit_q && !sf_hit_q) ||
                       (!(l_hit_q && {1'b0, l_start_q} + 32'(l_len_q) == {1'b0, it_q.pos}) &&
                        !(r_hit_q && end_q == {1'b0, r_start_q}) && !fc_hit_q)) begin
            res_q <= plain_res(ST_FULL, 1'b0);
          end else begin
            res_q <= plain_res(ST_ACC, 1'b0);
            if (l_hit_q && {1'b0, l_start_q} + 32'(l_len_q) == {1'b0, it_q.pos}) begin
              if (r_hit_q && end_q == {1'b0, r_start_q}) begin
                chunk_len_q[l_idx_q] <= l_len_q + len_q + r_len_q;
                chunk_vld_q[r_idx_q] <= 1'b0;
              end else begin
                chunk_len_q[l_idx_q] <= l_len_q + len_q;
              end
            end else if (r_hit_q && end_q == {1'b0, r_start_q}) begin
              chunk_start_q[r_idx_q] <= it_q.pos;
              chunk_len_q[r_idx_q]   <= r_len_q + len_q;
            end else begin
              chunk_vld_q[fc_idx_q]   <= 1'b1;
              chunk_start_q[fc_idx_q] <= it_q.pos;
              chunk_len_q[fc_idx_q]   <= len_q;
            end
            if (sm_hit_q) begin
              stamp_vld_q[sm_idx_q] <= 1'b1;
              stamp_pos_q[sm_idx_q] <= it_q.pos;
              stamp_val_q[sm_idx_q] <= it_q.time_val;
            end else begin
              stamp_vld_q[sf_idx_q] <= 1'b1;
              stamp_pos_q[sf_idx_q] <= it_q.pos;
              stamp_val_q[sf_idx_q] <= it_q.time_val;
            end
            pskip_q <= prefix_q;
            pleft_q <= len_q;
            widx_q  <= it_q.pos[SB_AW-1:0];
          end
        end

        S_ESCAN: begin
          any_q   <= anyh || s_v;
          b_hit_q <= bh || (s_v && s_t >= it_q.time_val);
          if (s_v && s_t >= it_q.time_val && (!bh || s_p < b_pos_q)) begin
            b_pos_q <= s_p;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_EDO;
          end
        end

        S_EDO: begin
          if (!any_q) begin
            res_q     <= plain_res(ST_ACC, 1'b1);
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end else if (!b_hit_q) begin
            // Every stamp is older than the expiry time: start over.
            chunk_vld_q <= '0;
            stamp_vld_q <= '0;
            head_q      <= '0;
            fill_q      <= '0;
            res_q       <= plain_res(ST_ACC, 1'b1);
            res_vld_q   <= 1'b1;
            state_q     <= S_IDLE;
          end else if (b_pos_q > head_q) begin
            fill_q    <= ({1'b0, b_pos_q - head_q} >= 32'(fill_q)) ? '0
                         : fill_q - LEN_W'(b_pos_q - head_q);
            head_q    <= b_pos_q;
            hdr_cln_q <= 1'b0;
            ret_q     <= S_EFIN;
            state_q   <= S_CLA;
          end else begin
            state_q <= S_EFIN;
          end
        end

        S_EFIN: begin
          res_q     <= plain_res(ST_ACC, fill_q == '0);
          res_vld_q <= 1'b1;
          state_q   <= S_IDLE;
        end

        S_RSCAN: begin
          a_hit_q <= ah || (c_v && c_s <= it_q.pos);
          if (c_v && c_s <= it_q.pos && (!ah || c_s > a_start_q)) begin
            a_start_q <= c_s;
            a_len_q   <= c_l;
          end
          b_hit_q <= bh || (s_v && s_p <= it_q.pos);
          if (s_v && s_p <= it_q.pos && (!bh || s_p > b_pos_q)) begin
            b_pos_q <= s_p;
            b_val_q <= s_t;
          end
          scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
          if (scan_last) begin
            state_q <= S_RFIN;
          end
        end

        S_RFIN: begin
          res_q     <= rd_res;
          res_vld_q <= 1'b1;
          state_q   <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/stream_reassembly_buffer_unit.sv */
// Stream reassembly buffer: one request at a time. A payload byte is handled
// in the idle state; a read, an expire and a header that passes its first
// checks walk the 16-entry chunk and timestamp tables, one entry per cycle.
// Reset clears the window and both tables at once; the byte store is not
// cleared and holds undefined data until written.
module stream_reassembly_buffer_unit
  import srb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stream_pos, seg_len, captured_len, time_value, data_byte, zero pad
  input  logic [135:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, found, contiguous_len, time_out, data_out, window_empty, zero pad
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= CAP_RST;
      cfg_q.max_gap  <= GAP_RST;
      cfg_q.allow    <= ABG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: cfg_q.capacity <= cfg_wdata_i;
        CFG_MAX_GAP:  cfg_q.max_gap  <= cfg_wdata_i;
        CFG_ALLOW:    cfg_q.allow    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  srb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_ready_i  (q_ready)
  );

  srb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_ready_o   (q_ready),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, res.empty, res.data, res.time_val, res.contig,
                         res.found, res.status};

endmodule
